[rtl/core/uer_pkg.sv]
// Shared types, codes and constants for the ultrasonic echo ranger.
package uer_pkg;

	// Width of the tick counter, the timeout register and the pulse width.
	localparam int unsigned TICK_W = 24;
	// Width of the distance field in 1/16 cm.
	localparam int unsigned DIST_W = 23;

	// Default timing.
	localparam int unsigned TRIGGER_HIGH_TICKS = 10;
	localparam int unsigned DEFAULT_TIMEOUT    = 30000;

	// Measurement status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_RISE_TOUT = 2'd1;
	localparam logic [1:0] STATUS_FALL_TOUT = 2'd2;

	// Measurement phase codes.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
	localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
	localparam logic [2:0] PH_WAIT_RISE = 3'd3;
	localparam logic [2:0] PH_MEASURE   = 3'd4;

	// Distance is floor(width * 8 / 29). The reciprocal floor(2^32 / 29) is
	// pre-scaled by 8; the estimate is low by at most one and is corrected.
	localparam int unsigned      DIST_SHIFT   = 32;
	localparam int unsigned      DIST_RECIP_W = 31;
	localparam logic [30:0]      DIST_RECIP   = 31'd1184818560;
	localparam logic [DIST_W+3:0] DIST_DIVISOR = 27'd29;

	// One input request.
	typedef struct packed {
		logic start_req;
		logic echo_level;
	} uer_in_t;

	// One result.
	typedef struct packed {
		logic                trigger_out;
		logic                busy_res;
		logic                done_res;
		logic [1:0]          status;
		logic [TICK_W-1:0]   pulse_width;
		logic [DIST_W-1:0]   distance;
	} uer_out_t;

endpackage

[rtl/core/ultrasonic_echo_ranger_top.sv]
// Ultrasonic echo ranger: trigger sequencing, echo timing and distance pipeline.
//
// Each input request is one microsecond tick carrying start_req and the sampled
// echo level; every request yields exactly one result carrying the trigger
// level for that tick, busy and done flags, status, echo width and distance in
// 1/16 cm. Both channels use valid/ready and a request moves on an edge where
// both are high.
// A request passes three registered stages: the phase machine updates on
// acceptance into stage one, stage two forms the reciprocal product for the
// distance, and stage three corrects the quotient and holds the result.
// Throughput is one request per cycle while in_ready is high; the phase register
// and tick counter are updated in the same cycle a request is accepted.
// Every stage has its own valid bit, so when the receiver stalls the pipeline
// keeps filling empty stages and in_ready drops only once all three are full.
// The timeout register is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce;
// zero selects DEFAULT_TIMEOUT ticks. Reset clears the phase to idle, the counter,
// the timeout register and all stage valid bits.
module ultrasonic_echo_ranger_top #(
	parameter int unsigned TRIGGER_HIGH_TICKS = uer_pkg::TRIGGER_HIGH_TICKS,
	parameter int unsigned DEFAULT_TIMEOUT    = uer_pkg::DEFAULT_TIMEOUT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [uer_pkg::TICK_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  uer_pkg::uer_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output uer_pkg::uer_out_t            out_data
);

	localparam int unsigned TW = uer_pkg::TICK_W;
	localparam int unsigned DW = uer_pkg::DIST_W;
	localparam int unsigned PW = TW + uer_pkg::DIST_RECIP_W;
	localparam logic [TW-1:0] TRIG_TICKS = TW'(TRIGGER_HIGH_TICKS);
	localparam logic [TW-1:0] DEF_TOUT   = TW'(DEFAULT_TIMEOUT);

	logic [TW-1:0]     timeout_q;
	logic [2:0]        phase_q;
	logic [TW-1:0]     cnt_q;
	logic [2:0]        phase_nxt;
	logic [TW-1:0]     cnt_nxt;
	logic [TW-1:0]     limit;
	uer_pkg::uer_out_t res_nxt;
	logic              in_fire;

	logic              valid_s1, valid_s2, valid_s3;
	logic              rdy_s2, rdy_s3;
	uer_pkg::uer_out_t res_s1, res_s2, res_s3;
	logic [PW-1:0]     prod_s2;

	logic [DW-1:0]     quot_est;
	logic [DW+3:0]     dividend;
	logic [DW+3:0]     rem;
	logic [DW-1:0]     quot;
	uer_pkg::uer_out_t res_fin;

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	assign limit = (timeout_q != '0) ? timeout_q : DEF_TOUT;

	// Pipeline handshake: each stage takes a new request when empty or draining.
	assign rdy_s3    = !valid_s3 || out_ready;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign in_ready  = !valid_s1 || rdy_s2;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = valid_s3;
	assign out_data  = res_s3;

	// Phase machine: next phase, counter and result fields for one tick.
	always_comb begin
		phase_nxt           = phase_q;
		cnt_nxt             = cnt_q;
		res_nxt             = '0;
		res_nxt.busy_res    = 1'b1;
		case (phase_q)
			uer_pkg::PH_TRIG_LOW: begin
				phase_nxt = uer_pkg::PH_TRIG_HIGH;
				cnt_nxt   = '0;
			end
			uer_pkg::PH_TRIG_HIGH: begin
				res_nxt.trigger_out = 1'b1;
				cnt_nxt             = cnt_q + TW'(1);
				if (cnt_nxt >= TRIG_TICKS) begin
					phase_nxt = uer_pkg::PH_WAIT_RISE;
					cnt_nxt   = '0;
				end
			end
			uer_pkg::PH_WAIT_RISE: begin
				if (in_data.echo_level) begin
					phase_nxt = uer_pkg::PH_MEASURE;
					cnt_nxt   = TW'(1);
				end else if (cnt_q >= limit) begin
					res_nxt.done_res = 1'b1;
					res_nxt.status   = uer_pkg::STATUS_RISE_TOUT;
				end else begin
					cnt_nxt = cnt_q + TW'(1);
				end
			end
			uer_pkg::PH_MEASURE: begin
				if (!in_data.echo_level) begin
					res_nxt.done_res    = 1'b1;
					res_nxt.status      = uer_pkg::STATUS_OK;
					res_nxt.pulse_width = cnt_q;
				end else if (cnt_q >= limit) begin
					res_nxt.done_res = 1'b1;
					res_nxt.status   = uer_pkg::STATUS_FALL_TOUT;
				end else begin
					cnt_nxt = cnt_q + TW'(1);
				end
			end
			default: begin
				// Idle, and unused codes which behave as idle.
				if (in_data.start_req) begin
					phase_nxt = uer_pkg::PH_TRIG_LOW;
					cnt_nxt   = TW'(1);
				end else begin
					phase_nxt        = uer_pkg::PH_IDLE;
					res_nxt.busy_res = 1'b0;
				end
			end
		endcase
		// A finished or timed-out measurement returns to idle.
		if (res_nxt.done_res) begin
			phase_nxt        = uer_pkg::PH_IDLE;
			cnt_nxt          = '0;
			res_nxt.busy_res = 1'b0;
		end
	end

	// Phase and counter advance once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else if (in_fire) begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Quotient correction: the reciprocal estimate is at most one too small.
	always_comb begin
		quot_est         = prod_s2[uer_pkg::DIST_SHIFT +: DW];
		dividend         = {res_s2.pulse_width, 3'b000};
		rem              = dividend - {4'b0000, quot_est} * uer_pkg::DIST_DIVISOR;
		quot             = (rem >= uer_pkg::DIST_DIVISOR) ? quot_est + DW'(1) : quot_est;
		res_fin          = res_s2;
		res_fin.distance = quot;
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1 <= res_nxt;
		end
		if (rdy_s2 && valid_s1) begin
			res_s2  <= res_s1;
			prod_s2 <= PW'(res_s1.pulse_width) * PW'(uer_pkg::DIST_RECIP);
		end
		if (rdy_s3 && valid_s2) begin
			res_s3 <= res_fin;
		end
	end

	// A finishing tick never reports busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.done_res |-> !res_s1.busy_res)
		else $error("done result reported busy");

	// Completion returns the phase machine to idle with a cleared counter.
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res_nxt.done_res |=> phase_q == uer_pkg::PH_IDLE && cnt_q == '0)
		else $error("phase not idle after completion");

	// Width and distance are zero unless a measurement ends well.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !(res_s3.done_res && res_s3.status == uer_pkg::STATUS_OK)
		|-> res_s3.pulse_width == '0 && res_s3.distance == '0)
		else $error("width or distance set without a good measurement");

endmodule

[test/tb_ultrasonic_echo_ranger_top.sv]
// Testbench for the ultrasonic echo ranger: directed and random ticks checked against a predictor.
module tb_ultrasonic_echo_ranger_top;

	localparam int unsigned TW = uer_pkg::TICK_W;
	localparam int unsigned DW = uer_pkg::DIST_W;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	// The block is three stages deep; a few spare cycles cover it.
	localparam int unsigned DRAIN_CYCLES = 6;
	// Length of the receiver hold-off in the backpressure test.
	localparam int HOLD_CYCLES = 120;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [TW-1:0]     cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	uer_pkg::uer_in_t  in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	uer_pkg::uer_out_t out_data;

	// Predictor state and its copy of the timeout register.
	logic [2:0]        cur_phase = uer_pkg::PH_IDLE;
	logic [TW-1:0]     cur_count = '0;
	logic [TW-1:0]     cur_timeout = '0;

	uer_pkg::uer_out_t expected_results[$];
	int          error_count = 0;
	int          ticks_sent = 0;
	int unsigned cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	// A toggle of hold_req asks the receiver for one counted hold-off.
	logic        hold_req = 1'b0;
	logic        hold_ack = 1'b0;
	int          hold_left = 0;

	ultrasonic_echo_ranger_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Predict the result of one tick and advance the phase machine.
	function automatic uer_pkg::uer_out_t range_tick(input uer_pkg::uer_in_t t);
		uer_pkg::uer_out_t r;
		logic [TW-1:0]     lim;
		logic [63:0]       prod;
		r = '0;
		r.busy_res = 1'b1;
		lim = (cur_timeout == '0) ? TW'(uer_pkg::DEFAULT_TIMEOUT) : cur_timeout;
		case (cur_phase)
			uer_pkg::PH_TRIG_LOW: begin
				cur_phase = uer_pkg::PH_TRIG_HIGH;
				cur_count = '0;
			end
			uer_pkg::PH_TRIG_HIGH: begin
				r.trigger_out = 1'b1;
				cur_count = cur_count + TW'(1);
				if (cur_count >= TW'(uer_pkg::TRIGGER_HIGH_TICKS)) begin
					cur_phase = uer_pkg::PH_WAIT_RISE;
					cur_count = '0;
				end
			end
			uer_pkg::PH_WAIT_RISE: begin
				if (t.echo_level) begin
					cur_phase = uer_pkg::PH_MEASURE;
					cur_count = TW'(1);
				end else if (cur_count >= lim) begin
					r.done_res = 1'b1;
					r.status = uer_pkg::STATUS_RISE_TOUT;
				end else begin
					cur_count = cur_count + TW'(1);
				end
			end
			uer_pkg::PH_MEASURE: begin
				if (!t.echo_level) begin
					r.done_res = 1'b1;
					r.status = uer_pkg::STATUS_OK;
					r.pulse_width = cur_count;
				end else if (cur_count >= lim) begin
					r.done_res = 1'b1;
					r.status = uer_pkg::STATUS_FALL_TOUT;
				end else begin
					cur_count = cur_count + TW'(1);
				end
			end
			default: begin
				// Unused codes fall back to idle as well.
				if (t.start_req) begin
					cur_phase = uer_pkg::PH_TRIG_LOW;
					cur_count = TW'(1);
				end else begin
					cur_phase = uer_pkg::PH_IDLE;
					r.busy_res = 1'b0;
				end
			end
		endcase
		if (r.done_res) begin
			cur_phase = uer_pkg::PH_IDLE;
			cur_count = '0;
			r.busy_res = 1'b0;
		end
		prod = 64'(r.pulse_width) * 64'd8;
		r.distance = DW'(prod / 64'd29);
		return r;
	endfunction

	// Offer one request, wait for it to be taken, and record its expected result.
	task automatic send_tick(input logic start, input logic echo);
		uer_pkg::uer_in_t item;
		item.start_req = start;
		item.echo_level = echo;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(range_tick(item));
		ticks_sent++;
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [TW-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_timeout = value;
	endtask

	// One measurement: start tick, trigger ticks with noise, a low wait, a high
	// run and an optional falling edge. The last tick always requests a start.
	task automatic run_ranging(input int rise_lows, input int high_len, input bit end_low);
		int total;
		total = rise_lows + high_len + (end_low ? 1 : 0);
		send_tick(1'b1, 1'($urandom_range(1)));
		repeat (1 + uer_pkg::TRIGGER_HIGH_TICKS)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		for (int i = 0; i < total; i++) begin
			send_tick((i == total - 1) ? 1'b1 : 1'($urandom_range(1)),
				(i >= rise_lows) && (i < rise_lows + high_len));
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// Idle ticks with the echo high are ignored.
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		set_timeout(TW'(1));
		// Width of one tick, rise timeout, fall timeout.
		run_ranging(0, 1, 1'b1);
		run_ranging(2, 0, 1'b0);
		run_ranging(0, 2, 1'b0);
	endtask

	task automatic test_timeout_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// Zero selects the default limit, so long waits finish normally.
		set_timeout('0);
		run_ranging(40, 50, 1'b1);
		set_timeout('1);
		run_ranging(3, 5, 1'b1);
		set_timeout(TW'(4));
		run_ranging(1, 4, 1'b1);
	endtask

	// The receiver holds off while the sender keeps offering, so the block backs up.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		settle();
		hold_req <= ~hold_req;
		run_ranging(2, 6, 1'b1);
		repeat (10) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		settle();
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int budget);
		int lim;
		int cap;
		int stop_at;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if ($urandom_range(3) == 0)
			set_timeout(TW'($urandom));
		else
			set_timeout(TW'($urandom_range(24, 1)));
		lim = (cur_timeout == '0) ? uer_pkg::DEFAULT_TIMEOUT : int'(cur_timeout);
		cap = (lim + 2 < 30) ? lim + 2 : 30;
		stop_at = ticks_sent + budget;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(99) < 85) begin
				run_ranging($urandom_range(cap, 0), $urandom_range(cap, 1),
					$urandom_range(9) != 0);
			end else begin
				repeat ($urandom_range(4, 1))
					send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	// Receiver: random stalls, or a counted hold-off when one is asked for.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		uer_pkg::uer_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result arrived with no request outstanding");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("trigger_out", 32'(want.trigger_out), 32'(out_data.trigger_out));
				check_field("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
				check_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
				check_field("status", 32'(want.status), 32'(out_data.status));
				check_field("pulse_width", 32'(want.pulse_width), 32'(out_data.pulse_width));
				check_field("distance", 32'(want.distance), 32'(out_data.distance));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_timeout_extremes();
		test_backpressure();
		test_random(0, 0, 120);
		test_random(72, 0, 120);
		test_random(0, 72, 120);
		test_random(9, 9, 120);
		settle();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
